// ===== src/uvje_pkg.sv =====
// Shared types, character codes and helpers of the JSON string escaper.
package uvje_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned SLOT_COUNT  = 4;

  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5c;
  localparam logic [7:0] CHAR_U      = 8'h75;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;

  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7e;
  localparam logic [7:0] LEAD_LO   = 8'hc2;
  localparam logic [7:0] LEAD2_HI  = 8'hdf;
  localparam logic [7:0] LEAD3_HI  = 8'hef;
  localparam logic [7:0] LEAD_HI   = 8'hf4;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hbf;

  // How one byte of a record is written out.
  typedef enum logic [1:0] {
    MODE_LIT,
    MODE_PAIR,
    MODE_ESC
  } uvje_mode_e;

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_SLOT,
    PH_CLOSE
  } uvje_phase_e;

  typedef struct packed {
    uvje_mode_e mode;
    logic [7:0] data;
  } uvje_slot_t;

  // All the output caused by one input byte: optional opening quote, up to
  // four bytes each written in its own mode, and an optional closing quote.
  typedef struct packed {
    logic                         open;
    logic                         close;
    logic [2:0]                   n;
    uvje_slot_t [SLOT_COUNT-1:0]  slots;
  } uvje_rec_t;

  function automatic uvje_slot_t mk_slot(input uvje_mode_e mode, input logic [7:0] data);
    uvje_slot_t s;
    s.mode = mode;
    s.data = data;
    return s;
  endfunction

  // Lowercase hexadecimal digit.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'h0, nib};
    end else begin
      c = 8'h57 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

// ===== src/uvje_front.sv =====
// Front end: UTF-8 sequence tracking and classification of each input byte.
module uvje_front import uvje_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       string_last_i,
  output logic       push_o,
  output uvje_rec_t  rec_o
);

  logic       open_q, open_d;
  logic [7:0] lead_q, lead_d;
  logic [2:0] exp_q, exp_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] cont_q [2];
  logic [7:0] cont_d [2];

  uvje_rec_t  rec;
  logic [2:0] idx;
  logic       fresh;
  logic       cont_ok;
  logic [7:0] b;

  assign b = in_byte_i;

  always_comb begin
    cont_ok = (b >= CONT_LO) && (b <= CONT_HI);
    if (cnt_q == 2'd0) begin
      if ((lead_q == 8'he0 && b < 8'ha0) || (lead_q == 8'hed && b > 8'h9f) ||
          (lead_q == 8'hf0 && b < 8'h90) || (lead_q == 8'hf4 && b > 8'h8f)) begin
        cont_ok = 1'b0;
      end
    end
  end

  always_comb begin
    rec       = '0;
    idx       = 3'd0;
    fresh     = 1'b0;
    open_d    = open_q;
    lead_d    = lead_q;
    exp_d     = exp_q;
    cnt_d     = cnt_q;
    cont_d    = cont_q;
    rec.open  = !open_q;

    if (exp_q == 3'd0) begin
      fresh = 1'b1;
    end else if (!cont_ok) begin
      // The pending sequence fails: escape what is held, then start afresh.
      rec.slots[idx[1:0]] = mk_slot(MODE_ESC, lead_q);
      idx = idx + 3'd1;
      if (cnt_q >= 2'd1) begin
        rec.slots[idx[1:0]] = mk_slot(MODE_ESC, cont_q[0]);
        idx = idx + 3'd1;
      end
      if (cnt_q >= 2'd2) begin
        rec.slots[idx[1:0]] = mk_slot(MODE_ESC, cont_q[1]);
        idx = idx + 3'd1;
      end
      exp_d = 3'd0;
      cnt_d = 2'd0;
      fresh = 1'b1;
    end else if (({1'b0, cnt_q} + 3'd2) >= exp_q) begin
      rec.slots[idx[1:0]] = mk_slot(MODE_LIT, lead_q);
      idx = idx + 3'd1;
      if (cnt_q >= 2'd1) begin
        rec.slots[idx[1:0]] = mk_slot(MODE_LIT, cont_q[0]);
        idx = idx + 3'd1;
      end
      if (cnt_q >= 2'd2) begin
        rec.slots[idx[1:0]] = mk_slot(MODE_LIT, cont_q[1]);
        idx = idx + 3'd1;
      end
      rec.slots[idx[1:0]] = mk_slot(MODE_LIT, b);
      idx = idx + 3'd1;
      exp_d = 3'd0;
      cnt_d = 2'd0;
    end else begin
      cont_d[cnt_q[0]] = b;
      cnt_d = cnt_q + 2'd1;
    end

    if (fresh) begin
      if (b == CHAR_QUOTE || b == CHAR_BSLASH) begin
        rec.slots[idx[1:0]] = mk_slot(MODE_PAIR, b);
        idx = idx + 3'd1;
      end else if (b >= PRINT_LO && b <= PRINT_HI) begin
        rec.slots[idx[1:0]] = mk_slot(MODE_LIT, b);
        idx = idx + 3'd1;
      end else if (b >= LEAD_LO && b <= LEAD_HI) begin
        lead_d = b;
        cnt_d  = 2'd0;
        if (b <= LEAD2_HI) begin
          exp_d = 3'd2;
        end else if (b <= LEAD3_HI) begin
          exp_d = 3'd3;
        end else begin
          exp_d = 3'd4;
        end
      end else begin
        rec.slots[idx[1:0]] = mk_slot(MODE_ESC, b);
        idx = idx + 3'd1;
      end
    end

    if (string_last_i) begin
      // A sequence cut short by the end of the string is escaped.
      if (exp_d != 3'd0) begin
        rec.slots[idx[1:0]] = mk_slot(MODE_ESC, lead_d);
        idx = idx + 3'd1;
        if (cnt_d >= 2'd1) begin
          rec.slots[idx[1:0]] = mk_slot(MODE_ESC, cont_d[0]);
          idx = idx + 3'd1;
        end
        if (cnt_d >= 2'd2) begin
          rec.slots[idx[1:0]] = mk_slot(MODE_ESC, cont_d[1]);
          idx = idx + 3'd1;
        end
      end
      exp_d     = 3'd0;
      cnt_d     = 2'd0;
      rec.close = 1'b1;
      open_d    = 1'b0;
    end else begin
      open_d = 1'b1;
    end
    rec.n = idx;
  end

  assign rec_o  = rec;
  assign push_o = accept_i && (rec.open || rec.close || (rec.n != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      lead_q <= 8'h00;
      exp_q  <= 3'd0;
      cnt_q  <= 2'd0;
    end else if (accept_i) begin
      open_q <= open_d;
      lead_q <= lead_d;
      exp_q  <= exp_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cont_q <= cont_d;
    end
  end

endmodule

// ===== src/uvje_queue.sv =====
// Short record queue between the front end and the character sequencer.
module uvje_queue import uvje_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  uvje_rec_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output uvje_rec_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  uvje_rec_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/uvje_back.sv =====
// Back end: expands records into output characters behind an output register.
module uvje_back import uvje_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rec_valid_i,
  input  uvje_rec_t  rec_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       string_done_o
);

  uvje_rec_t   cur_q;
  logic        cur_valid_q;
  uvje_phase_e ph_q, ph_d, start_ph;
  logic [1:0]  slot_q, slot_d;
  logic [2:0]  sub_q, sub_d;

  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic        run_last_q;
  logic        string_done_q;

  logic        adv, emit, done, load;
  logic [7:0]  ch;
  logic [2:0]  sub_end;
  uvje_slot_t  s;

  assign adv  = !out_valid_q || !out_stall_i;
  assign emit = cur_valid_q && adv;
  assign load = rec_valid_i && (!cur_valid_q || (emit && done));
  assign s    = cur_q.slots[slot_q];

  always_comb begin
    if (rec_i.open) begin
      start_ph = PH_OPEN;
    end else if (rec_i.n != 3'd0) begin
      start_ph = PH_SLOT;
    end else begin
      start_ph = PH_CLOSE;
    end
  end

  // Next position within the current record.
  always_comb begin
    ph_d   = ph_q;
    slot_d = slot_q;
    sub_d  = sub_q;
    done   = 1'b0;
    case (s.mode)
      MODE_LIT:  sub_end = 3'd0;
      MODE_PAIR: sub_end = 3'd1;
      MODE_ESC:  sub_end = 3'd5;
      default:   sub_end = 3'd0;
    endcase
    case (ph_q)
      PH_OPEN: begin
        if (cur_q.n != 3'd0) begin
          ph_d   = PH_SLOT;
          slot_d = 2'd0;
          sub_d  = 3'd0;
        end else if (cur_q.close) begin
          ph_d = PH_CLOSE;
        end else begin
          done = 1'b1;
        end
      end
      PH_SLOT: begin
        if (sub_q != sub_end) begin
          sub_d = sub_q + 3'd1;
        end else if (({1'b0, slot_q} + 3'd1) < cur_q.n) begin
          slot_d = slot_q + 2'd1;
          sub_d  = 3'd0;
        end else if (cur_q.close) begin
          ph_d = PH_CLOSE;
        end else begin
          done = 1'b1;
        end
      end
      PH_CLOSE: done = 1'b1;
      default:  done = 1'b1;
    endcase
  end

  // Character at the current position.
  always_comb begin
    ch = CHAR_QUOTE;
    case (ph_q)
      PH_SLOT: begin
        case (s.mode)
          MODE_LIT:  ch = s.data;
          MODE_PAIR: ch = (sub_q == 3'd0) ? CHAR_BSLASH : s.data;
          MODE_ESC: begin
            case (sub_q)
              3'd0:    ch = CHAR_BSLASH;
              3'd1:    ch = CHAR_U;
              3'd2:    ch = CHAR_ZERO;
              3'd3:    ch = CHAR_ZERO;
              3'd4:    ch = hex_char(s.data[7:4]);
              default: ch = hex_char(s.data[3:0]);
            endcase
          end
          default:   ch = s.data;
        endcase
      end
      default: ch = CHAR_QUOTE;
    endcase
  end

  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      ph_q        <= PH_OPEN;
      slot_q      <= 2'd0;
      sub_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
        ph_q        <= start_ph;
        slot_q      <= 2'd0;
        sub_q       <= 3'd0;
      end else if (emit) begin
        cur_valid_q <= !done;
        ph_q        <= ph_d;
        slot_q      <= slot_d;
        sub_q       <= sub_d;
      end
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= rec_i;
    end
    if (emit) begin
      out_char_q    <= ch;
      run_last_q    <= done;
      string_done_q <= (ph_q == PH_CLOSE);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign run_last_o    = run_last_q;
  assign string_done_o = string_done_q;

  // The closing quote is always the final character of its record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> run_last_o)
    else $error("closing quote not marked as end of run");

  // A record in flight never points beyond its own byte slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && ph_q == PH_SLOT |-> ({1'b0, slot_q} < cur_q.n))
    else $error("slot index beyond record length");

  // A record without any output would stall the sequencer for nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_q.open || cur_q.close || cur_q.n != 3'd0))
    else $error("empty record reached the sequencer");

  // A completed output transfer with a current record always brings a new character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && cur_valid_q |=> out_valid_o)
    else $error("output bubble while a record was pending");

endmodule

// ===== src/utf8_validating_json_escaper.sv =====
// Top level of the UTF-8 validating JSON string escaper.
//
// Input channel: one raw string byte per transfer (in_byte_i), with
// string_last_i high on the final byte. Output channel: one character of the
// quoted JSON text per transfer; run_last_o marks the last character caused
// by an input byte and string_done_o marks the closing quote.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// The front end classifies each byte in the cycle it is accepted and writes a
// record into a two-entry queue; the back end turns records into characters,
// one per cycle, into an output register. With the back end idle, a byte's
// first character goes through the queue, the current record and the output
// register. Throughput is one character per cycle while out_stall_i is low,
// so unchanged text runs at one byte per cycle. A byte that expands to
// several characters (an escape is six) holds the back end for all of them,
// and the queue then raises in_stall_o. Bytes that only extend a pending UTF-8
// sequence give no output and take no queue entry, but wait while it is full.
// Reset clears the sequence tracker, the queue and the output register.
// While out_stall_i is high the output character holds and, once the queue
// fills, in_stall_o is raised.
module utf8_validating_json_escaper import uvje_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       string_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       string_done_o
);

  logic      q_full, q_valid, q_pop, push;
  uvje_rec_t front_rec, q_rec;

  assign in_stall_o = q_full;

  uvje_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_valid_i && !q_full),
    .in_byte_i     (in_byte_i),
    .string_last_i (string_last_i),
    .push_o        (push),
    .rec_o         (front_rec)
  );

  uvje_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rec)
  );

  uvje_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (q_valid),
    .rec_i         (q_rec),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

endmodule
